// File: src/ppom_pkg.sv
// shared types and action codes for the order matcher
// no dependencies
`default_nettype none
package ppom_pkg;
	typedef enum logic [1:0] {
		ACT_ASK = 2'd0,
		ACT_BID = 2'd1,
		ACT_MATCH = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_M_ASK_RD,
		ST_M_ASK_WT,
		ST_M_BID_RD,
		ST_M_EVAL,
		ST_M_FIN
	} state_t;

	localparam int MAX_RESULTS = 32;
endpackage
`default_nettype wire

// File: src/ppom_book.sv
// one side of the book: price, amount and flag memory with one read port
// depends on nothing but its parameters
`default_nettype none
module ppom_book #(
	parameter int DEPTH = 16,
	parameter int VB = 48,
	localparam int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [VB-1:0] wprice,
	input wire logic [VB-1:0] wamount,
	input wire logic wsim,
	input wire logic [AW-1:0] raddr,
	output logic [VB-1:0] rprice,
	output logic [VB-1:0] ramount,
	output logic rsim
);
	logic [VB-1:0] price_mem [DEPTH];
	logic [VB-1:0] amount_mem [DEPTH];
	logic sim_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			price_mem[waddr] <= wprice;
			amount_mem[waddr] <= wamount;
			sim_mem[waddr] <= wsim;
		end
		rprice <= price_mem[raddr];
		ramount <= amount_mem[raddr];
		rsim <= sim_mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/price_priority_order_matcher_core.sv
// load: entries that rank behind the new order move up one place each, then it is written
// match: each ask is walked against the bids until filled or out of bids, then the run
// closes; a sale waits while another is pending and the output register is full
// throughput: one item at a time, the next beat is taken once the sequencer is idle
// reset: counts, overflow mark, sequencer and output valid clear asynchronously; book
// memory contents are left as they are and only entries below the counts are read
`default_nettype none
module price_priority_order_matcher_core
	import ppom_pkg::*;
#(
	parameter int BOOK_DEPTH = 16,
	parameter int VALUE_BITS = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire logic [VALUE_BITS-1:0] price,
	input wire logic [VALUE_BITS-1:0] amount,
	input wire logic sim_user,
	output logic out_valid,
	input wire logic out_ready,
	output logic sale_valid,
	output logic [VALUE_BITS-1:0] sale_price,
	output logic [VALUE_BITS-1:0] sale_amount,
	output logic bid_sale,
	output logic sale_sim_user,
	output logic book_overflow,
	output logic last
);
	localparam int AW = $clog2(BOOK_DEPTH);
	localparam int CW = AW + 1;
	localparam int VB = VALUE_BITS;

	state_t state_q, state_d;

	// counts and held item
	logic [CW-1:0] ask_cnt_q, bid_cnt_q;
	logic ovf_q;
	logic side_q;                       // 1 for bid side
	logic [VB-1:0] nprice_q, namount_q;
	logic nsim_q;
	logic [CW-1:0] pos_q;               // insertion position walking down
	logic [CW-1:0] ai_q, bi_q;          // match indices
	logic [VB-1:0] ap_q, aa_q;          // current ask price and amount left
	logic asim_q;
	logic [5:0] nres_q;                 // sales found in this run

	// memory ports
	logic a_we, b_we;
	logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
	logic [VB-1:0] a_wp, a_wa, b_wp, b_wa;
	logic a_ws, b_ws;
	logic [VB-1:0] a_rp, a_ra, b_rp, b_ra;
	logic a_rs, b_rs;

	// pending sale: held until the walk shows whether another one follows
	logic pend_v_q;
	logic [VB-1:0] pend_p_q, pend_a_q;
	logic pend_bs_q, pend_ss_q;

	// output register
	logic o_valid_q;
	logic o_sv_q, o_bs_q, o_ss_q, o_ovf_q, o_last_q;
	logic [VB-1:0] o_p_q, o_a_q;

	// sequencer strobes
	logic ins_done, sale_go, fin_go;

	// read data of the side being inserted into
	logic [VB-1:0] rd_p, rd_a;
	logic rd_s;
	logic shift_up;
	logic bid_ok, bid_covers;
	logic [CW-1:0] pos_m1;
	logic at_cap;
	logic acc;

	ppom_book #(.DEPTH(BOOK_DEPTH), .VB(VB)) u_ask (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wprice(a_wp), .wamount(a_wa),
		.wsim(a_ws), .raddr(a_raddr), .rprice(a_rp), .ramount(a_ra), .rsim(a_rs)
	);
	ppom_book #(.DEPTH(BOOK_DEPTH), .VB(VB)) u_bid (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wprice(b_wp), .wamount(b_wa),
		.wsim(b_ws), .raddr(b_raddr), .rprice(b_rp), .ramount(b_ra), .rsim(b_rs)
	);

	assign rd_p = side_q ? b_rp : a_rp;
	assign rd_a = side_q ? b_ra : a_ra;
	assign rd_s = side_q ? b_rs : a_rs;
	// asks ascend, bids descend; equal prices stay below the new order
	assign shift_up = side_q ? (rd_p < nprice_q) : (rd_p > nprice_q);

	// match compare: bid has amount left and meets the ask price
	assign bid_ok = (b_ra != '0) && (b_rp >= ap_q);
	assign bid_covers = b_ra >= aa_q;
	assign pos_m1 = pos_q - CW'(1);
	assign at_cap = (nres_q == 6'(MAX_RESULTS - 1));

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ins_done = 1'b0;
		sale_go = 1'b0;
		fin_go = 1'b0;
		a_we = 1'b0;
		b_we = 1'b0;
		a_waddr = pos_q[AW-1:0];
		b_waddr = pos_q[AW-1:0];
		a_wp = nprice_q;
		a_wa = namount_q;
		a_ws = nsim_q;
		b_wp = nprice_q;
		b_wa = namount_q;
		b_ws = nsim_q;
		a_raddr = pos_m1[AW-1:0];
		b_raddr = pos_m1[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (action)
						ACT_ASK: begin
							if (ask_cnt_q != CW'(BOOK_DEPTH)) begin
								state_d = ST_INS_RD;
							end
						end
						ACT_BID: begin
							if (bid_cnt_q != CW'(BOOK_DEPTH)) begin
								state_d = ST_INS_RD;
							end
						end
						ACT_MATCH: state_d = ST_M_ASK_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_RD: begin
				// read entry pos-1 unless at bottom, where the new order lands
				if (pos_q == '0) begin
					a_we = !side_q;
					b_we = side_q;
					ins_done = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (shift_up) begin
					// move entry up one place
					a_wp = rd_p; a_wa = rd_a; a_ws = rd_s;
					b_wp = rd_p; b_wa = rd_a; b_ws = rd_s;
					a_we = !side_q;
					b_we = side_q;
					state_d = ST_INS_RD;
				end else begin
					a_we = !side_q;
					b_we = side_q;
					ins_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_M_ASK_RD: begin
				a_raddr = ai_q[AW-1:0];
				if (ai_q == ask_cnt_q || bid_cnt_q == '0) begin
					state_d = ST_M_FIN;
				end else begin
					state_d = ST_M_ASK_WT;
				end
			end
			ST_M_ASK_WT: state_d = ST_M_BID_RD;
			ST_M_BID_RD: begin
				b_raddr = bi_q[AW-1:0];
				if (bi_q == bid_cnt_q) begin
					state_d = ST_M_ASK_RD;
				end else begin
					state_d = ST_M_EVAL;
				end
			end
			ST_M_EVAL: begin
				// keep the read address so the bid data holds during a stall
				b_raddr = bi_q[AW-1:0];
				b_waddr = bi_q[AW-1:0];
				b_wp = b_rp;
				b_ws = b_rs;
				b_wa = bid_covers ? (b_ra - aa_q) : '0;
				if (!bid_ok) begin
					state_d = ST_M_BID_RD;
				end else if (!pend_v_q || !o_valid_q) begin
					// the earlier sale moves out, this one becomes pending
					sale_go = 1'b1;
					b_we = 1'b1;
					if (at_cap) begin
						state_d = ST_M_FIN;
					end else if (bid_covers) begin
						state_d = ST_M_ASK_RD;
					end else begin
						state_d = ST_M_BID_RD;
					end
				end
			end
			ST_M_FIN: begin
				// last beat of the run: pending sale or the empty item
				if (!o_valid_q) begin
					fin_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// counts, overflow mark and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ask_cnt_q <= '0;
			bid_cnt_q <= '0;
			ovf_q <= 1'b0;
			pend_v_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (ins_done) begin
				if (side_q) bid_cnt_q <= bid_cnt_q + CW'(1);
				else ask_cnt_q <= ask_cnt_q + CW'(1);
			end else if (fin_go) begin
				// run ends: clear book
				ask_cnt_q <= '0;
				bid_cnt_q <= '0;
			end
			if (acc && ((action == ACT_ASK && ask_cnt_q == CW'(BOOK_DEPTH)) ||
			    (action == ACT_BID && bid_cnt_q == CW'(BOOK_DEPTH)))) begin
				ovf_q <= 1'b1;
			end else if (fin_go) begin
				ovf_q <= 1'b0;
			end
			if (sale_go) begin
				pend_v_q <= 1'b1;
			end else if (fin_go) begin
				pend_v_q <= 1'b0;
			end
			if ((sale_go && pend_v_q) || fin_go) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// held item, walk registers and payloads
	always_ff @(posedge clk) begin
		if (acc) begin
			side_q <= (action == ACT_BID);
			nprice_q <= price;
			namount_q <= amount;
			nsim_q <= sim_user;
			pos_q <= (action == ACT_BID) ? bid_cnt_q : ask_cnt_q;
			ai_q <= '0;
			nres_q <= '0;
		end
		if (state_q == ST_INS_CMP && shift_up) begin
			pos_q <= pos_m1;
		end
		if (state_q == ST_M_ASK_WT) begin
			ap_q <= a_rp;
			aa_q <= a_ra;
			asim_q <= a_rs;
			bi_q <= '0;
		end
		if (state_q == ST_M_BID_RD && bi_q == bid_cnt_q) begin
			ai_q <= ai_q + CW'(1);
		end
		if (state_q == ST_M_EVAL && !bid_ok) begin
			bi_q <= bi_q + CW'(1);
		end
		if (sale_go) begin
			pend_p_q <= ap_q;
			pend_a_q <= bid_covers ? aa_q : b_ra;
			pend_bs_q <= b_rs;
			pend_ss_q <= b_rs | asim_q;
			nres_q <= nres_q + 6'd1;
			if (bid_covers) begin
				// ask filled: next ask
				ai_q <= ai_q + CW'(1);
			end else begin
				aa_q <= aa_q - b_ra;
				bi_q <= bi_q + CW'(1);
			end
			if (pend_v_q) begin
				o_sv_q <= 1'b1;
				o_p_q <= pend_p_q;
				o_a_q <= pend_a_q;
				o_bs_q <= pend_bs_q;
				o_ss_q <= pend_ss_q;
				o_ovf_q <= ovf_q;
				o_last_q <= 1'b0;
			end
		end
		if (fin_go) begin
			o_sv_q <= pend_v_q;
			o_p_q <= pend_v_q ? pend_p_q : '0;
			o_a_q <= pend_v_q ? pend_a_q : '0;
			o_bs_q <= pend_v_q & pend_bs_q;
			o_ss_q <= pend_v_q & pend_ss_q;
			o_ovf_q <= ovf_q;
			o_last_q <= 1'b1;
		end
	end

	assign out_valid = o_valid_q;
	assign sale_valid = o_sv_q;
	assign sale_price = o_p_q;
	assign sale_amount = o_a_q;
	assign bid_sale = o_bs_q;
	assign sale_sim_user = o_ss_q;
	assign book_overflow = o_ovf_q;
	assign last = o_last_q;

`ifndef SYNTHESIS
	a_cnt_ask: assert property (@(posedge clk) disable iff (!arst_n)
		ask_cnt_q <= CW'(BOOK_DEPTH)) else $error("ask count past depth");
	a_cnt_bid: assert property (@(posedge clk) disable iff (!arst_n)
		bid_cnt_q <= CW'(BOOK_DEPTH)) else $error("bid count past depth");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sale_price) &&
		$stable(sale_amount) && $stable(last)) else $error("beat changed while waiting");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sale_valid |-> last) else $error("empty item not last");
`endif
endmodule
`default_nettype wire
